>>> src/swtm_pkg.sv
// ----------------------------------------------------------------------------
// swtm_pkg: shared types and codes for the sequence window triangle mask
// Mask mode codes, register indexes, queue entry and configuration structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swtm_pkg;

  // Mask mode codes; 6 and 7 pass everything through
  localparam logic [2:0] MODE_SEQUENCE   = 3'd0;
  localparam logic [2:0] MODE_WINDOW     = 3'd1;
  localparam logic [2:0] MODE_UPPER      = 3'd2;
  localparam logic [2:0] MODE_LOWER      = 3'd3;
  localparam logic [2:0] MODE_UPPER_DIAG = 3'd4;
  localparam logic [2:0] MODE_LOWER_DIAG = 3'd5;

  // Input item kinds
  localparam logic ITEM_LOAD = 1'b0;
  localparam logic ITEM_DATA = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_MASK_MODE     = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT     = 3'd1;
  localparam logic [2:0] REG_COLUMN_COUNT  = 3'd2;
  localparam logic [2:0] REG_REPEAT_COUNT  = 3'd3;
  localparam logic [2:0] REG_BATCH_COUNT   = 3'd4;
  localparam logic [2:0] REG_WINDOW_RADIUS = 3'd5;
  localparam logic [2:0] REG_FILL_BITS     = 3'd6;

  localparam int QUEUE_DEPTH = 4;

  // One transaction handed from the front to the back
  typedef struct packed {
    logic        is_data;
    logic        is_end;
    logic [15:0] addr;     // table index for loads, row for data
    logic [15:0] col;
    logic [31:0] payload;  // entry value for loads, element for data
  } queue_entry_t;

  typedef struct packed {
    logic [2:0]  mask_mode;
    logic [10:0] row_count;
    logic [15:0] column_count;
    logic [15:0] repeat_count;
    logic [15:0] batch_count;
  } count_cfg_t;

  typedef struct packed {
    logic [2:0]  mask_mode;
    logic [15:0] window_radius;
    logic [31:0] fill_bits;
  } back_cfg_t;

endpackage

>>> src/swtm_front.sv
// ----------------------------------------------------------------------------
// swtm_front: item intake and position tracking
// Accepts items, drops out-of-range loads, walks the batch/row/column/repeat
// counters for data elements and pushes one queue entry per kept item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swtm_front #(
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  swtm_pkg::count_cfg_t      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [9:0]                entry_index,
  input  logic signed [31:0]        entry_value,
  input  logic [ELEMENT_WIDTH-1:0]  element_bits,
  input  logic                      q_full,
  output logic                      q_push,
  output swtm_pkg::queue_entry_t    q_entry
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [15:0]      batch_pos, batch_pos_next;
  logic [ROW_W-1:0] row_pos, row_pos_next;
  logic [15:0]      col_pos, col_pos_next;
  logic [15:0]      rep_pos, rep_pos_next;

  logic [16:0] rows_lim, cols_lim, reps_lim, bats_lim;
  logic        rep_last, col_last, row_last, bat_last, tensor_end;
  logic        accept, is_data, index_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_data  = (mode == swtm_pkg::ITEM_DATA);
  assign index_ok = (17'(entry_index) < 17'(MAX_ROWS));

  // Effective limits: zero acts as one, rows saturate at the table depth
  always_comb begin
    if (cfg.row_count == 11'd0) begin
      rows_lim = 17'd1;
    end else if (17'(cfg.row_count) > 17'(MAX_ROWS)) begin
      rows_lim = 17'(MAX_ROWS);
    end else begin
      rows_lim = 17'(cfg.row_count);
    end
    cols_lim = (cfg.column_count == 16'd0) ? 17'd1 : 17'(cfg.column_count);
    bats_lim = (cfg.batch_count == 16'd0) ? 17'd1 : 17'(cfg.batch_count);
    if (cfg.mask_mode == swtm_pkg::MODE_SEQUENCE && cfg.repeat_count != 16'd0) begin
      reps_lim = 17'(cfg.repeat_count);
    end else begin
      reps_lim = 17'd1;
    end
  end

  assign rep_last   = (17'(rep_pos) + 17'd1) >= reps_lim;
  assign col_last   = (17'(col_pos) + 17'd1) >= cols_lim;
  assign row_last   = (17'(row_pos) + 17'd1) >= rows_lim;
  assign bat_last   = (17'(batch_pos) + 17'd1) >= bats_lim;
  assign tensor_end = rep_last && col_last && row_last && bat_last;

  always_comb begin
    rep_pos_next   = rep_pos;
    col_pos_next   = col_pos;
    row_pos_next   = row_pos;
    batch_pos_next = batch_pos;
    if (tensor_end) begin
      rep_pos_next   = '0;
      col_pos_next   = '0;
      row_pos_next   = '0;
      batch_pos_next = '0;
    end else begin
      rep_pos_next = rep_last ? 16'd0 : rep_pos + 16'd1;
      if (rep_last) begin
        col_pos_next = col_last ? 16'd0 : col_pos + 16'd1;
        if (col_last) begin
          row_pos_next = row_last ? '0 : row_pos + ROW_W'(1);
          if (row_last) begin
            batch_pos_next = bat_last ? 16'd0 : batch_pos + 16'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_pos   <= '0;
      col_pos   <= '0;
      row_pos   <= '0;
      batch_pos <= '0;
    end else if (accept && is_data) begin
      rep_pos   <= rep_pos_next;
      col_pos   <= col_pos_next;
      row_pos   <= row_pos_next;
      batch_pos <= batch_pos_next;
    end
  end

  // Drop loads beyond the table; everything else goes to the back
  assign q_push = accept && (is_data || index_ok);

  always_comb begin
    q_entry.is_data = is_data;
    q_entry.is_end  = is_data && tensor_end;
    q_entry.col     = col_pos;
    if (is_data) begin
      q_entry.addr    = 16'(row_pos);
      q_entry.payload = 32'(element_bits);
    end else begin
      q_entry.addr    = 16'(entry_index);
      q_entry.payload = entry_value;
    end
  end

endmodule

>>> src/swtm_queue.sv
// ----------------------------------------------------------------------------
// swtm_queue: short first-word-fall-through queue
// Decouples the front from the back so that each side can stall alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swtm_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  swtm_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output logic                   not_empty,
  output swtm_pkg::queue_entry_t pop_entry
);

  localparam int DEPTH = swtm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  swtm_pkg::queue_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/swtm_back.sv
// ----------------------------------------------------------------------------
// swtm_back: table access, mask decision and output register
// Writes loads into the row table, reads the row entry for each element,
// decides the mask and holds the result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swtm_back #(
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  swtm_pkg::back_cfg_t       cfg,
  input  logic                      q_not_empty,
  input  swtm_pkg::queue_entry_t    q_entry,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ELEMENT_WIDTH-1:0]  value_bits,
  output logic                      was_masked,
  output logic                      end_of_tensor
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [31:0] row_table [MAX_ROWS];
  logic [31:0] rd_data;

  swtm_pkg::queue_entry_t a_entry;
  logic a_valid, a_go;
  logic masked;
  logic signed [33:0] lim_s, col_s, rad_s, lo_s, hi_s;

  assign a_go  = a_valid && (!out_valid || out_ready);
  assign q_pop = q_not_empty && (!a_valid || a_go);

  always_ff @(posedge clk) begin
    if (q_pop && !q_entry.is_data) begin
      row_table[q_entry.addr[ROW_W-1:0]] <= q_entry.payload;
    end
  end

  // Read the row entry as the element enters the decision stage
  always_ff @(posedge clk) begin
    if (q_pop && q_entry.is_data) begin
      rd_data <= row_table[q_entry.addr[ROW_W-1:0]];
      a_entry <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (q_pop && q_entry.is_data) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  assign lim_s = $signed({{2{rd_data[31]}}, rd_data});
  assign col_s = $signed({18'b0, a_entry.col});
  assign rad_s = $signed({18'b0, cfg.window_radius});
  assign lo_s  = lim_s - rad_s;
  assign hi_s  = lim_s + rad_s;

  always_comb begin
    case (cfg.mask_mode)
      swtm_pkg::MODE_SEQUENCE:   masked = (col_s >= lim_s);
      swtm_pkg::MODE_WINDOW:     masked = (col_s < lo_s) || (col_s > hi_s);
      swtm_pkg::MODE_UPPER:      masked = (a_entry.col > a_entry.addr);
      swtm_pkg::MODE_LOWER:      masked = (a_entry.col < a_entry.addr);
      swtm_pkg::MODE_UPPER_DIAG: masked = (a_entry.col >= a_entry.addr);
      swtm_pkg::MODE_LOWER_DIAG: masked = (a_entry.col <= a_entry.addr);
      default:                   masked = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      value_bits    <= masked ? cfg.fill_bits[ELEMENT_WIDTH-1:0]
                              : a_entry.payload[ELEMENT_WIDTH-1:0];
      was_masked    <= masked;
      end_of_tensor <= a_entry.is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/sequence_window_triangle_mask_top.sv
// ----------------------------------------------------------------------------
// sequence_window_triangle_mask_top: streaming sequence/window/triangle mask
// Elements pass the queue, the decision stage and the output register; one item
// per cycle sustained while out_ready is high, else back-pressure stalls the intake.
// Reset clears counters, queue and output valid; the row table is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequence_window_triangle_mask_top #(
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [9:0]                entry_index,
  input  logic signed [31:0]        entry_value,
  input  logic [ELEMENT_WIDTH-1:0]  element_bits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ELEMENT_WIDTH-1:0]  value_bits,
  output logic                      was_masked,
  output logic                      end_of_tensor
);

  logic [2:0]  mask_mode;
  logic [10:0] row_count;
  logic [15:0] column_count, repeat_count, batch_count, window_radius;
  logic [31:0] fill_bits;
  logic [2:0]  reg_index;
  logic        cfg_write;

  swtm_pkg::count_cfg_t   count_cfg;
  swtm_pkg::back_cfg_t    back_cfg;
  swtm_pkg::queue_entry_t push_entry, pop_entry;
  logic q_push, q_full, q_pop, q_not_empty;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_mode     <= swtm_pkg::MODE_SEQUENCE;
      row_count     <= 11'd1;
      column_count  <= 16'd1;
      repeat_count  <= 16'd1;
      batch_count   <= 16'd1;
      window_radius <= 16'd0;
      fill_bits     <= 32'd0;
    end else if (cfg_write) begin
      case (reg_index)
        swtm_pkg::REG_MASK_MODE:     mask_mode     <= pwdata[2:0];
        swtm_pkg::REG_ROW_COUNT:     row_count     <= pwdata[10:0];
        swtm_pkg::REG_COLUMN_COUNT:  column_count  <= pwdata[15:0];
        swtm_pkg::REG_REPEAT_COUNT:  repeat_count  <= pwdata[15:0];
        swtm_pkg::REG_BATCH_COUNT:   batch_count   <= pwdata[15:0];
        swtm_pkg::REG_WINDOW_RADIUS: window_radius <= pwdata[15:0];
        swtm_pkg::REG_FILL_BITS:     fill_bits     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      swtm_pkg::REG_MASK_MODE:     prdata = 32'(mask_mode);
      swtm_pkg::REG_ROW_COUNT:     prdata = 32'(row_count);
      swtm_pkg::REG_COLUMN_COUNT:  prdata = 32'(column_count);
      swtm_pkg::REG_REPEAT_COUNT:  prdata = 32'(repeat_count);
      swtm_pkg::REG_BATCH_COUNT:   prdata = 32'(batch_count);
      swtm_pkg::REG_WINDOW_RADIUS: prdata = 32'(window_radius);
      swtm_pkg::REG_FILL_BITS:     prdata = fill_bits;
      default:                     prdata = 32'd0;
    endcase
  end

  assign count_cfg.mask_mode    = mask_mode;
  assign count_cfg.row_count    = row_count;
  assign count_cfg.column_count = column_count;
  assign count_cfg.repeat_count = repeat_count;
  assign count_cfg.batch_count  = batch_count;

  assign back_cfg.mask_mode     = mask_mode;
  assign back_cfg.window_radius = window_radius;
  assign back_cfg.fill_bits     = fill_bits;

  swtm_front #(
    .MAX_ROWS      (MAX_ROWS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (count_cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .element_bits (element_bits),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  swtm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  swtm_back #(
    .MAX_ROWS      (MAX_ROWS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (back_cfg),
    .q_not_empty   (q_not_empty),
    .q_entry       (pop_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value_bits    (value_bits),
    .was_masked    (was_masked),
    .end_of_tensor (end_of_tensor)
  );

`ifndef SYNTHESIS
  // Reset leaves no result pending and the intake open
  a_reset_idle: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("result pending or intake closed after reset");

  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue push while full");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_not_empty)
    else $error("queue pop while empty");
`endif

endmodule
